FILE: rtl/stereo_bass_treble_biquad_cascade_assert.svh
// assertion macros for the tone control cascade
// used by the top level only, expects clk and rst_n in scope
`ifndef STEREO_BASS_TREBLE_BIQUAD_CASCADE_ASSERT_SVH
`define STEREO_BASS_TREBLE_BIQUAD_CASCADE_ASSERT_SVH

// same-cycle implication
`define BSBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define BSBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/bsbt_pkg.sv
// shared constants and types for the tone control cascade
// no dependencies
package bsbt_pkg;

  localparam int RECIP_FRAC_BITS  = 44;
  localparam int COEF_SCALE_SHIFT = 6;
  localparam int STAGE_SHIFT      = RECIP_FRAC_BITS - COEF_SCALE_SHIFT;
  localparam int OUT_SHIFT        = COEF_SCALE_SHIFT + 1;

  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BASS_B0B1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASS_B2A1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASS_A2RC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TREBLE_B0B1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TREBLE_B2A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TREBLE_A2RC = 3'd5;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mul_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic [63:0] b0b1;
    logic [63:0] b2a1;
    logic [63:0] a2rc;
  } coef_t;

  typedef struct packed {
    logic [15:0] bx1;
    logic [15:0] bx2;
    logic [31:0] by1;
    logic [31:0] by2;
    logic [31:0] tx1;
    logic [31:0] tx2;
    logic [31:0] ty1;
    logic [31:0] ty2;
  } hist_t;

endpackage

FILE: rtl/bsbt_in_if.sv
// input sample channel: valid, ready, a channel select and one sample word
// depends on bsbt_pkg
interface bsbt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bsbt_pkg::SAMPLE_W-1:0]  sample_in;
  logic                                  channel;
  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

FILE: rtl/bsbt_out_if.sv
// result channel: valid, ready and one filtered sample word
// depends on bsbt_pkg
interface bsbt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bsbt_pkg::SAMPLE_W-1:0]  sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/bsbt_cfg_if.sv
// configuration write channel: valid, ready, register index and data word
// depends on bsbt_pkg
interface bsbt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bsbt_pkg::CFG_IDX_W-1:0]    index;
  logic [bsbt_pkg::CFG_DAT_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bsbt_mul.sv
// bit-serial multiply-accumulate: acc +/- a * b modulo 2^64, one bit of b per cycle
// depends on bsbt_pkg
module bsbt_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  bsbt_pkg::mul_cmd_t cmd,
  input  logic [63:0]        a,
  input  logic [31:0]        b,
  output bsbt_pkg::mul_stat_t stat,
  output logic [63:0]        acc
);
  import bsbt_pkg::*;

  logic [63:0] m_r, acc_r;
  logic [31:0] q_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r, neg_r;
  logic        sub;

  // top bit of b carries negative weight
  assign sub = (cnt_r == 5'd31) ^ neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      m_r   <= a;
      q_r   <= b;
      neg_r <= cmd.neg;
      if (cmd.clear) acc_r <= '0;
    end else if (busy_r) begin
      if (q_r[0]) acc_r <= sub ? acc_r - m_r : acc_r + m_r;
      m_r <= {m_r[62:0], 1'b0};
      q_r <= {1'b0, q_r[31:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign acc       = acc_r;
endmodule

FILE: rtl/stereo_bass_treble_biquad_cascade.sv
// stereo bass and treble shelving biquads in cascade, one shared bit-serial multiplier
// an accepted sample word runs through 12 products on the multiplier before its result is valid
// one sample word at a time: the next is taken once the result sits in the
// output register, and a result held by out_ch.ready holds the next one back
// synchronous active-low reset clears coefficients, histories and control
// depends on bsbt_pkg, bsbt_in_if, bsbt_out_if, bsbt_cfg_if, bsbt_mul
module stereo_bass_treble_biquad_cascade (
  input  logic       clk,
  input  logic       rst_n,
  bsbt_in_if.sink    in_ch,
  bsbt_out_if.source out_ch,
  bsbt_cfg_if.sink   cfg_ch
);
  import bsbt_pkg::*;
  `include "stereo_bass_treble_biquad_cascade_assert.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [2:0] T_RECIP = 3'd5;

  logic [1:0]  state_r;
  logic [2:0]  term_r;
  logic        stage_r, ch_r;
  logic [15:0] smp_r;
  logic [31:0] sx_r;
  logic [15:0] res_r;
  logic [15:0] out_r;
  logic        out_valid_r;
  coef_t       coef_r [2];
  hist_t       hist_r [2];

  coef_t       cc;
  hist_t       hh;
  mul_cmd_t    cmd;
  mul_stat_t   stat;
  logic [63:0] op_a, mul_acc;
  logic [31:0] op_b;
  logic signed [63:0] sres, vout;
  logic [15:0] sat;

  assign cc = coef_r[stage_r];
  assign hh = hist_r[ch_r];

  always_comb begin
    cmd.start = (state_r == ST_ISSUE);
    cmd.clear = (term_r == 3'd0) || (term_r == T_RECIP);
    cmd.neg   = (term_r == 3'd3) || (term_r == 3'd4);
    op_a = mul_acc;
    op_b = cc.a2rc[31:0];
    case (term_r)
      3'd0: begin
        op_a = {{32{sx_r[31]}}, sx_r};
        op_b = cc.b0b1[63:32];
      end
      3'd1: begin
        op_a = stage_r ? {{32{hh.tx1[31]}}, hh.tx1} : {{48{hh.bx1[15]}}, hh.bx1};
        op_b = cc.b0b1[31:0];
      end
      3'd2: begin
        op_a = stage_r ? {{32{hh.tx2[31]}}, hh.tx2} : {{48{hh.bx2[15]}}, hh.bx2};
        op_b = cc.b2a1[63:32];
      end
      3'd3: begin
        op_a = stage_r ? {{32{hh.ty1[31]}}, hh.ty1} : {{32{hh.by1[31]}}, hh.by1};
        op_b = cc.b2a1[31:0];
      end
      3'd4: begin
        op_a = stage_r ? {{32{hh.ty2[31]}}, hh.ty2} : {{32{hh.by2[31]}}, hh.by2};
        op_b = cc.a2rc[63:32];
      end
      default: begin
        op_a = mul_acc;
        op_b = cc.a2rc[31:0];
      end
    endcase
  end

  bsbt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .a     (op_a),
    .b     (op_b),
    .stat  (stat),
    .acc   (mul_acc)
  );

  assign sres = $signed(mul_acc) >>> STAGE_SHIFT;
  assign vout = sres >>> OUT_SHIFT;

  always_comb begin
    if (vout > 64'sd32767)       sat = 16'h7FFF;
    else if (vout < -64'sd32768) sat = 16'h8000;
    else                         sat = vout[15:0];
  end

  // configuration words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BASS_B0B1:   coef_r[0].b0b1 <= cfg_ch.data;
        REG_BASS_B2A1:   coef_r[0].b2a1 <= cfg_ch.data;
        REG_BASS_A2RC:   coef_r[0].a2rc <= cfg_ch.data;
        REG_TREBLE_B0B1: coef_r[1].b0b1 <= cfg_ch.data;
        REG_TREBLE_B2A1: coef_r[1].b2a1 <= cfg_ch.data;
        REG_TREBLE_A2RC: coef_r[1].a2rc <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_r      <= '0;
      stage_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r[0]   <= '0;
      hist_r[1]   <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ch_r    <= in_ch.channel;
            smp_r   <= in_ch.sample_in;
            sx_r    <= {{16{in_ch.sample_in[15]}}, in_ch.sample_in};
            term_r  <= '0;
            stage_r <= 1'b0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (stat.done) begin
            if (term_r != T_RECIP) begin
              term_r  <= term_r + 3'd1;
              state_r <= ST_ISSUE;
            end else if (!stage_r) begin
              hist_r[ch_r].bx2 <= hh.bx1;
              hist_r[ch_r].bx1 <= smp_r;
              hist_r[ch_r].by2 <= hh.by1;
              hist_r[ch_r].by1 <= sres[31:0];
              sx_r    <= sres[31:0];
              stage_r <= 1'b1;
              term_r  <= '0;
              state_r <= ST_ISSUE;
            end else begin
              hist_r[ch_r].tx2 <= hh.tx1;
              hist_r[ch_r].tx1 <= sx_r;
              hist_r[ch_r].ty2 <= hh.ty1;
              hist_r[ch_r].ty1 <= sres[31:0];
              res_r   <= sat;
              state_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sample_out = out_r;

  `BSBT_ASSERT_IMP(a_start_idle, cmd.start, !stat.busy)
  `BSBT_ASSERT_IMP(a_done_wait, stat.done, state_r == ST_WAIT)
  `BSBT_ASSERT_NXT(a_out_from_fin, !out_valid_r && state_r != ST_FIN, !out_valid_r)
endmodule

FILE: tb/bsbt_checker.sv
// checker for the tone control cascade: watches the sample, result and register channels
// predicts each filtered sample word and compares it with the result channel
// depends on bsbt_pkg, bsbt_in_if, bsbt_out_if, bsbt_cfg_if
module bsbt_checker (
  input  logic clk,
  input  logic rst_n,
  bsbt_in_if.sink  in_mon,
  bsbt_out_if.sink out_mon,
  bsbt_cfg_if.sink cfg_mon,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsbt_pkg::*;

  logic [63:0] coef_regs [6];
  logic [31:0] bass_x  [4];
  logic [31:0] bass_y  [4];
  logic [31:0] treb_x  [4];
  logic [31:0] treb_y  [4];
  logic signed [15:0] expected_samples [$];

  assign pending = expected_samples.size();

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic signed [63:0] biquad_stage(
    input logic [63:0] r01, input logic [63:0] r2a1, input logic [63:0] ra2rc,
    input logic signed [63:0] x, input logic signed [63:0] x1,
    input logic signed [63:0] x2, input logic signed [63:0] y1,
    input logic signed [63:0] y2);
    logic signed [63:0] acc;
    acc = 64'(signed'(r01[63:32])) * x;
    acc += 64'(signed'(r01[31:0])) * x1;
    acc += 64'(signed'(r2a1[63:32])) * x2;
    acc -= 64'(signed'(r2a1[31:0])) * y1;
    acc -= 64'(signed'(ra2rc[63:32])) * y2;
    acc = acc * 64'(signed'(ra2rc[31:0]));
    return acc >>> STAGE_SHIFT;
  endfunction

  function automatic logic signed [15:0] filter_sample(input logic signed [15:0] smp,
                                                       input logic ch);
    logic [1:0] b, b1;
    logic signed [63:0] bass, treb, v;
    logic [31:0] bass32;
    b  = {ch, 1'b0};
    b1 = {ch, 1'b1};
    bass = biquad_stage(coef_regs[REG_BASS_B0B1], coef_regs[REG_BASS_B2A1],
                        coef_regs[REG_BASS_A2RC], 64'(smp),
                        64'(signed'(bass_x[b][15:0])), 64'(signed'(bass_x[b1][15:0])),
                        64'(signed'(bass_y[b])), 64'(signed'(bass_y[b1])));
    bass32 = bass[31:0];
    bass_x[b1] = bass_x[b];
    bass_x[b] = {16'd0, smp};
    bass_y[b1] = bass_y[b];
    bass_y[b] = bass32;
    treb = biquad_stage(coef_regs[REG_TREBLE_B0B1], coef_regs[REG_TREBLE_B2A1],
                        coef_regs[REG_TREBLE_A2RC], 64'(signed'(bass32)),
                        64'(signed'(treb_x[b])), 64'(signed'(treb_x[b1])),
                        64'(signed'(treb_y[b])), 64'(signed'(treb_y[b1])));
    treb_x[b1] = treb_x[b];
    treb_x[b] = bass32;
    treb_y[b1] = treb_y[b];
    treb_y[b] = treb[31:0];
    v = treb >>> OUT_SHIFT;
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      fail_count = 0;
      expected_samples.delete();
      foreach (coef_regs[i]) coef_regs[i] = '0;
      foreach (bass_x[i]) begin
        bass_x[i] = '0; bass_y[i] = '0; treb_x[i] = '0; treb_y[i] = '0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          report($sformatf("unexpected word %0d", out_mon.sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.sample_out !== want)
            report($sformatf("sample_out %0d, expected %0d", out_mon.sample_out, want));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < 6)
        coef_regs[cfg_mon.index] = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        expected_samples.push_back(filter_sample(in_mon.sample_in, in_mon.channel));
    end
  end
endmodule

FILE: tb/tb_top.sv
// top of the tone control cascade testbench: clock, reset, stimulus and verdict
// drives samples, register writes and result stalls; checking sits in bsbt_checker
// depends on bsbt_pkg, the three channel interfaces, bsbt_checker and the block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bsbt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   words_sent;
  int   phases_run;

  bsbt_in_if  in_ch ();
  bsbt_out_if out_ch ();
  bsbt_cfg_if cfg_ch ();

  stereo_bass_treble_biquad_cascade dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  bsbt_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_word(input logic signed [15:0] smp, input logic ch, input bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    in_ch.sample_in <= smp;
    in_ch.channel   <= ch;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    words_sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (450) @(negedge clk);
  endtask

  function automatic logic [63:0] pack_pair(input int hi, input int lo);
    return {32'(hi), 32'(lo)};
  endfunction

  // mode 1: bass gain one, treble gain 128 so the output tracks the input
  // mode 2: mild feedback on both stages, output near full scale
  task automatic load_coefs(input int mode);
    logic [63:0] v [6];
    case (mode)
      0: foreach (v[i]) v[i] = '0;
      1: begin
        v[0] = pack_pair(256, 0);   v[1] = pack_pair(0, 0); v[2] = pack_pair(0, 1 << 30);
        v[3] = pack_pair(32768, 0); v[4] = pack_pair(0, 0); v[5] = pack_pair(0, 1 << 30);
      end
      2: begin
        v[0] = pack_pair(280, -80);    v[1] = pack_pair(40, -60);
        v[2] = pack_pair(12, 1 << 30);
        v[3] = pack_pair(24000, 6000); v[4] = pack_pair(-2000, 30);
        v[5] = pack_pair(-9, 1 << 30);
      end
      3: foreach (v[i]) v[i] = {32'h7fffffff, 32'h80000000};
      4: foreach (v[i]) v[i] = '1;
      default: foreach (v[i]) v[i] = {$urandom, $urandom};
    endcase
    foreach (v[i]) write_reg(i[CFG_IDX_W-1:0], v[i]);
  endtask

  initial begin
    logic signed [15:0] smp;
    in_ch.valid = 1'b0; in_ch.sample_in = '0; in_ch.channel = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    words_sent = 0;
    phases_run = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // zero coefficients after reset
    send_word(16'sh7fff, 1'b0, 1'b0);
    send_word(16'sh8000, 1'b1, 1'b0);
    drain();

    // directed extremes under several settings
    for (int m = 1; m <= 4; m++) begin
      load_coefs(m);
      phases_run++;
      send_word(16'sh7fff, 1'b0, 1'b1);
      send_word(16'sh8000, 1'b1, 1'b0);
      send_word(16'sh8000, 1'b0, 1'b0);
      send_word(16'sh7fff, 1'b1, 1'b1);
      send_word(16'sh0000, 1'b0, 1'b0);
      drain();
    end

    // random phases with gentle and random coefficients
    for (int p = 0; p < 9; p++) begin
      load_coefs((p % 3 == 2) ? 5 : 1 + (p % 2));
      phases_run++;
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(0, 3))
          0: smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          1: smp = 16'($urandom_range(0, 255)) - 16'sd128;
          default: smp = 16'($urandom);
        endcase
        send_word(smp, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
        if (k == 25) while (pending != 0) @(negedge clk);
      end
      drain();
    end

    $display("%0d sample words sent over %0d coefficient settings, left and right",
             words_sent, phases_run);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
